/* design/potimer_pkg.sv */
package potimer_pkg;

    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_ADD    = 2'd1,
        OP_DELETE = 2'd2,
        OP_IGNORE = 2'd3
    } opcode_t;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    localparam logic KIND_FIRE = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    typedef struct packed {
        opcode_t       opcode;
        logic [15:0]   delta;
        logic [31:0]   period;
        logic          repeat_req;
        logic [15:0]   owner;
    } req_item_t;

    typedef struct packed {
        logic          kind;
        logic [15:0]   fired_owner;
        logic [15:0]   fired_delta;
        logic          removed;
        logic [1:0]    status;
        logic [4:0]    entry_count;
        logic          last;
    } rsp_item_t;

    typedef struct packed {
        logic [15:0]   owner;
        logic [31:0]   accum;
        logic [31:0]   limit;
        logic          rep;
    } entry_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD,
        S_LOAD,
        S_WALK,
        S_DONE
    } ctrl_state_t;

    typedef struct packed {
        logic accept;
        logic add;
        logic load;
        logic step;
        logic done;
    } potimer_cmd_t;

    typedef struct packed {
        opcode_t in_opcode;
        logic    live_zero;
        logic    walk_last;
        logic    step_ok;
        logic    out_free;
    } potimer_stat_t;

endpackage

/* design/potimer_ctrl.sv */
module potimer_ctrl
    import potimer_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  potimer_stat_t stat,
    output potimer_cmd_t  cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    case (stat.in_opcode)
                        OP_TICK:   state_next = S_LOAD;
                        OP_DELETE: state_next = S_LOAD;
                        OP_ADD:    state_next = S_ADD;
                        default:   state_next = S_DONE;
                    endcase
                end
            end
            S_ADD:
            begin
                cmd.add    = 1'b1;
                state_next = S_DONE;
            end
            S_LOAD:
            begin
                cmd.load   = 1'b1;
                state_next = stat.live_zero ? S_DONE : S_WALK;
            end
            S_WALK:
            begin
                if (stat.step_ok)
                begin
                    cmd.step = 1'b1;
                    if (stat.walk_last)
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.done   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

/* design/potimer_dp.sv */
module potimer_dp
    import potimer_pkg::*;
#(
    parameter int ENTRIES = 16
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  req_item_t     req,
    input  potimer_cmd_t  cmd,
    output potimer_stat_t stat,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output rsp_item_t     rsp
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);

    entry_t               mem [ENTRIES];
    entry_t               rdata_reg;
    req_item_t            op_reg;
    logic [CNT_W-1:0]     live_reg;
    logic [CNT_W-1:0]     live_next;
    logic [CNT_W-1:0]     walk_len_reg;
    logic [IDX_W-1:0]     rd_reg;
    logic [IDX_W-1:0]     wr_reg;
    logic                 found_reg;
    logic                 full_reg;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    rsp_item_t            out_item_reg;
    rsp_item_t            out_item_next;

    logic [32:0]          sum;
    logic [31:0]          acc_sat;
    logic [32:0]          diff;
    logic                 fire;
    logic                 match;
    logic                 drop;
    logic                 emits;
    logic                 out_free;
    logic                 walk_last;
    logic                 is_tick;
    logic                 is_del;
    logic                 mem_we;
    logic [IDX_W-1:0]     waddr;
    entry_t               wdata;
    logic                 mem_re;
    logic [IDX_W-1:0]     raddr;
    logic [1:0]           done_status;

    assign is_tick = (op_reg.opcode == OP_TICK);
    assign is_del  = (op_reg.opcode == OP_DELETE);

    // saturating add, then the period compare and subtract share one adder
    assign sum     = {1'b0, rdata_reg.accum} + 33'(op_reg.delta);
    assign acc_sat = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    assign diff    = {1'b0, acc_sat} - {1'b0, rdata_reg.limit};
    assign fire    = !diff[32];
    assign match   = !found_reg && (rdata_reg.owner == op_reg.owner);

    assign drop      = is_tick ? (fire && !rdata_reg.rep) : (is_del && match);
    assign emits     = is_tick && fire;
    assign out_free  = !out_valid_reg || !rsp_stall;
    assign walk_last = ((CNT_W'(rd_reg) + CNT_W'(1)) == walk_len_reg);

    assign stat.in_opcode = req.opcode;
    assign stat.live_zero = (live_reg == '0);
    assign stat.walk_last = walk_last;
    assign stat.step_ok   = !emits || out_free;
    assign stat.out_free  = out_free;

    // table write: append on add, compaction write while walking
    always_comb
    begin
        mem_we = 1'b0;
        waddr  = wr_reg;
        wdata  = rdata_reg;
        if (cmd.add)
        begin
            mem_we      = (live_reg != CNT_W'(ENTRIES));
            waddr       = live_reg[IDX_W-1:0];
            wdata.owner = op_reg.owner;
            wdata.accum = '0;
            wdata.limit = op_reg.period;
            wdata.rep   = op_reg.repeat_req;
        end
        else if (cmd.step)
        begin
            mem_we = !drop;
            if (is_tick)
            begin
                wdata.accum = fire ? diff[31:0] : acc_sat;
            end
        end
    end

    assign mem_re = cmd.load || (cmd.step && !walk_last);
    assign raddr  = cmd.load ? '0 : rd_reg + IDX_W'(1);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[waddr] <= wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg <= req;
        end
        if (cmd.load)
        begin
            walk_len_reg <= live_reg;
        end
        if (cmd.add)
        begin
            full_reg <= (live_reg == CNT_W'(ENTRIES));
        end
    end

    always_comb
    begin
        live_next = live_reg;
        if (cmd.add && (live_reg != CNT_W'(ENTRIES)))
        begin
            live_next = live_reg + CNT_W'(1);
        end
        else if (cmd.step && drop)
        begin
            live_next = live_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg  <= '0;
            rd_reg    <= '0;
            wr_reg    <= '0;
            found_reg <= 1'b0;
        end
        else
        begin
            live_reg <= live_next;
            if (cmd.load)
            begin
                rd_reg    <= '0;
                wr_reg    <= '0;
                found_reg <= 1'b0;
            end
            else if (cmd.step)
            begin
                rd_reg <= rd_reg + IDX_W'(1);
                if (!drop)
                begin
                    wr_reg <= wr_reg + IDX_W'(1);
                end
                if (is_del && match)
                begin
                    found_reg <= 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        case (op_reg.opcode)
            OP_ADD:    done_status = full_reg ? ST_FULL : ST_OK;
            OP_DELETE: done_status = found_reg ? ST_OK : ST_NOT_FOUND;
            default:   done_status = ST_OK;
        endcase
    end

    // output register, so the next item may start while a result waits
    always_comb
    begin
        out_valid_next = out_valid_reg && rsp_stall;
        out_item_next  = out_item_reg;
        if (cmd.step && emits)
        begin
            out_valid_next            = 1'b1;
            out_item_next.kind        = KIND_FIRE;
            out_item_next.fired_owner = rdata_reg.owner;
            out_item_next.fired_delta = op_reg.delta;
            out_item_next.removed     = drop;
            out_item_next.status      = ST_OK;
            out_item_next.entry_count = 5'(live_next);
            out_item_next.last        = 1'b0;
        end
        else if (cmd.done)
        begin
            out_valid_next            = 1'b1;
            out_item_next.kind        = KIND_DONE;
            out_item_next.fired_owner = '0;
            out_item_next.fired_delta = '0;
            out_item_next.removed     = 1'b0;
            out_item_next.status      = done_status;
            out_item_next.entry_count = 5'(live_reg);
            out_item_next.last        = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_item_reg;

    a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
        live_reg <= CNT_W'(ENTRIES))
        else $error("live count beyond table size");

    a_compact_behind: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> wr_reg <= rd_reg)
        else $error("compaction write ahead of read");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.done || (cmd.step && emits)) |-> out_free)
        else $error("result loaded while output register busy");

    a_drop_count: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step && drop) |=> live_reg == $past(live_reg) - CNT_W'(1))
        else $error("removal did not lower live count");

endmodule

/* design/periodic_oneshot_timer_table.sv */
// Table of up to ENTRIES software timers, one-shot or periodic, kept in insertion order in a
// table memory with one registered read port and one write port. Items are taken only between
// operations: an add passes through an add state and a done state, a tick or a delete through
// a load state, a walk that reads each live slot and writes it back compacted (skipped when
// the table is empty), and a done state. Each fire or done item waits in the output register;
// the walk holds on a fire, and the done state waits, while that register is full and stalled.
module periodic_oneshot_timer_table
    import potimer_pkg::*;
#(
    parameter int ENTRIES = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  req_item_t req,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output rsp_item_t rsp
);

    potimer_cmd_t  cmd;
    potimer_stat_t stat;

    potimer_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req_valid),
        .in_stall (req_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    potimer_dp #(
        .ENTRIES (ENTRIES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .stat      (stat),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule
